// File: design/fcw_pkg.sv
`default_nettype none
// ============================================================================
// fcw_pkg - shared types and constants of the chain walker
// Item kinds, queue entry layout, back-end states and table constants.
// ============================================================================
package fcw_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int MAX_BLOCKS      = 32;

    localparam logic [5:0] END_LINK = 6'h3F;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_START    = 2'd1;
    localparam logic [1:0] ERR_LINK     = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG = 2'd3;

    localparam logic MODE_LOAD = 1'b0;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_SKIP = 2'd1,
        KIND_WALK = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [4:0] idx;
        logic [5:0] link;
        logic [4:0] start;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_LINK = 1'b1
    } st_t;

    // Entries that can ever be addressed: the table is bounded by both
    // the configured depth and the block limit.
    function automatic int store_depth(int depth);
        return (depth < MAX_BLOCKS) ? depth : MAX_BLOCKS;
    endfunction

endpackage
`default_nettype wire

// File: design/fcw_front.sv
`default_nettype none
// ============================================================================
// fcw_front - intake and classification
// Accepts input beats, tags them as load, dropped load or walk, and holds
// them in a two-entry queue for the back end.
// ============================================================================
module fcw_front #(
    parameter int TABLE_DEPTH = fcw_pkg::TABLE_DEPTH_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_stall,
    input  wire               mode,
    input  wire         [4:0] entry_index,
    input  wire signed  [5:0] entry_link,
    input  wire         [4:0] start_block,
    output fcw_pkg::q_head_t  head,
    input  wire               pop
);

    localparam int STORE_DEPTH = fcw_pkg::store_depth(TABLE_DEPTH);

    fcw_pkg::item_t q_mem [2];
    fcw_pkg::item_t new_item;
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;
    logic           do_pop;

    always_comb
    begin
        new_item.idx   = entry_index;
        new_item.link  = $unsigned(entry_link);
        new_item.start = start_block;
        if (mode == fcw_pkg::MODE_LOAD)
        begin
            // drop loads that fall outside the store
            if ({1'b0, entry_index} < 6'(STORE_DEPTH))
                new_item.kind = fcw_pkg::KIND_LOAD;
            else
                new_item.kind = fcw_pkg::KIND_SKIP;
        end
        else
        begin
            new_item.kind = fcw_pkg::KIND_WALK;
        end
    end

    assign in_stall   = (cnt_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign do_pop     = pop && (cnt_reg != 2'd0);
    assign head.valid = (cnt_reg != 2'd0);
    assign head.item  = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= new_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// File: design/fcw_back.sv
`default_nettype none
// ============================================================================
// fcw_back - table store and chain walk
// Executes queued items: loads write the link store, walks follow links one
// store read per step and fill the output register.
// ============================================================================
module fcw_back #(
    parameter int TABLE_DEPTH = fcw_pkg::TABLE_DEPTH_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_wr_en,
    input  wire        [5:0] cfg_wr_data,
    input  fcw_pkg::q_head_t head,
    output logic             pop,
    output logic             out_valid,
    input  wire              out_stall,
    output logic       [5:0] position,
    output logic       [4:0] block,
    output logic             end_marker,
    output logic       [1:0] error,
    output logic       [5:0] block_count,
    output logic             last
);

    localparam int STORE_DEPTH = fcw_pkg::store_depth(TABLE_DEPTH);
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [5:0]    link_mem [STORE_DEPTH];
    logic [5:0]    rd_data_reg;
    logic          mem_we;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic [5:0]    table_size_reg;
    logic [5:0]    size;

    fcw_pkg::st_t  state_reg, state_next;
    logic [5:0]    count_reg, count_next;
    logic          out_valid_reg, out_valid_next;
    logic          can_emit;
    logic          emit;

    logic [5:0]    e_pos;
    logic [4:0]    e_blk;
    logic          e_mark;
    logic [1:0]    e_err;
    logic [5:0]    e_cnt;
    logic          e_last;

    logic [5:0]    pos_reg;
    logic [4:0]    blk_reg;
    logic          mark_reg;
    logic [1:0]    err_reg;
    logic [5:0]    cnt_reg;
    logic          last_reg;

    assign size = (table_size_reg < 6'(STORE_DEPTH)) ? table_size_reg : 6'(STORE_DEPTH);
    assign can_emit = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        emit       = 1'b0;
        e_pos      = '0;
        e_blk      = '0;
        e_mark     = 1'b0;
        e_err      = fcw_pkg::ERR_NONE;
        e_cnt      = '0;
        e_last     = 1'b0;

        case (state_reg)
            fcw_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    case (head.item.kind)
                        fcw_pkg::KIND_LOAD:
                        begin
                            pop    = 1'b1;
                            mem_we = 1'b1;
                        end
                        fcw_pkg::KIND_WALK:
                        begin
                            if (can_emit)
                            begin
                                pop  = 1'b1;
                                emit = 1'b1;
                                if ({1'b0, head.item.start} >= size)
                                begin
                                    e_err  = fcw_pkg::ERR_START;
                                    e_last = 1'b1;
                                end
                                else
                                begin
                                    e_blk      = head.item.start;
                                    rd_en      = 1'b1;
                                    rd_addr    = head.item.start[AW-1:0];
                                    count_next = 6'd1;
                                    state_next = fcw_pkg::ST_LINK;
                                end
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            fcw_pkg::ST_LINK:
            begin
                if (can_emit)
                begin
                    emit  = 1'b1;
                    e_pos = count_reg;
                    if (rd_data_reg == fcw_pkg::END_LINK)
                    begin
                        e_mark     = 1'b1;
                        e_cnt      = count_reg + 6'd1;
                        e_last     = 1'b1;
                        state_next = fcw_pkg::ST_IDLE;
                    end
                    else if (rd_data_reg[5] || rd_data_reg >= size)
                    begin
                        e_err      = fcw_pkg::ERR_LINK;
                        e_cnt      = count_reg;
                        e_last     = 1'b1;
                        state_next = fcw_pkg::ST_IDLE;
                    end
                    else if (count_reg >= size)
                    begin
                        e_err      = fcw_pkg::ERR_TOO_LONG;
                        e_cnt      = count_reg;
                        e_last     = 1'b1;
                        state_next = fcw_pkg::ST_IDLE;
                    end
                    else
                    begin
                        e_blk      = rd_data_reg[4:0];
                        rd_en      = 1'b1;
                        rd_addr    = rd_data_reg[AW-1:0];
                        count_next = count_reg + 6'd1;
                    end
                end
            end
            default:
            begin
                state_next = fcw_pkg::ST_IDLE;
            end
        endcase

        if (emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // link store: one write port for loads, one registered read for walks
    always_ff @(posedge clk)
    begin
        if (mem_we)
            link_mem[head.item.idx[AW-1:0]] <= head.item.link;
        if (rd_en)
            rd_data_reg <= link_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pos_reg  <= e_pos;
            blk_reg  <= e_blk;
            mark_reg <= e_mark;
            err_reg  <= e_err;
            cnt_reg  <= e_cnt;
            last_reg <= e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fcw_pkg::ST_IDLE;
            count_reg      <= 6'd0;
            out_valid_reg  <= 1'b0;
            table_size_reg <= 6'd32;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                table_size_reg <= cfg_wr_data;
        end
    end

    assign out_valid   = out_valid_reg;
    assign position    = pos_reg;
    assign block       = blk_reg;
    assign end_marker  = mark_reg;
    assign error       = err_reg;
    assign block_count = cnt_reg;
    assign last        = last_reg;

endmodule
`default_nettype wire

// File: design/fat_chain_walker_top.sv
`default_nettype none
// ============================================================================
// fat_chain_walker_top - file allocation table chain walker
// Loads next-block links into a small table and walks chains from a start
// block, giving one result beat per block, then an end marker or an error.
// ============================================================================
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  input    | in_valid / in_stall     | mode, entry_index, entry_link,
//           |                         | start_block
//  output   | out_valid / out_stall   | position, block, end_marker, error,
//           |                         | block_count, last
//  config   | cfg_wr_en (no wait)     | cfg_wr_data -> table_size
//
//  A walk over a chain makes one store read per link, since each step
//  needs the link just read to form the next address. A two-entry queue
//  between intake and walker keeps input beats flowing while the output
//  is stalled, until the queue is full. Reset clears queue, walker and
//  output valid and sets table_size to 32; the link store is not reset.
//
module fat_chain_walker_top #(
    parameter int TABLE_DEPTH = fcw_pkg::TABLE_DEPTH_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_wr_en,
    input  wire        [5:0] cfg_wr_data,
    input  wire              in_valid,
    output logic             in_stall,
    input  wire              mode,
    input  wire        [4:0] entry_index,
    input  wire signed [5:0] entry_link,
    input  wire        [4:0] start_block,
    output logic             out_valid,
    input  wire              out_stall,
    output logic       [5:0] position,
    output logic       [4:0] block,
    output logic             end_marker,
    output logic       [1:0] error,
    output logic       [5:0] block_count,
    output logic             last
);

    // queue head travels front -> back, pop returns
    fcw_pkg::q_head_t head;
    logic             pop;

    // intake: classify each beat and hold it in the queue
    fcw_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .entry_index (entry_index),
        .entry_link  (entry_link),
        .start_block (start_block),
        .head        (head),
        .pop         (pop)
    );

    // walker: store, link following and output register
    fcw_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position),
        .block       (block),
        .end_marker  (end_marker),
        .error       (error),
        .block_count (block_count),
        .last        (last)
    );

endmodule
`default_nettype wire

// File: design/fcw_checker.sv
`default_nettype none
// ============================================================================
// fcw_checker - port-level checks of the chain walker
// Watches the output channel for handshake and result-shape rules.
// ============================================================================
module fcw_checker (
    input wire       clk,
    input wire       rst_n,
    input wire       out_valid,
    input wire       out_stall,
    input wire [5:0] position,
    input wire [4:0] block,
    input wire       end_marker,
    input wire [1:0] error,
    input wire [5:0] block_count,
    input wire       last
);

    // hold a stalled beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position) && $stable(block)
            && $stable(last) && $stable(block_count))
        else $error("stalled output beat changed");

    // end marker closes the walk and counts itself
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_marker |-> last && block == 5'd0 && error == fcw_pkg::ERR_NONE
            && block_count == position + 6'd1)
        else $error("bad end marker beat");

    // an error closes the walk and does not count itself
    a_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error != fcw_pkg::ERR_NONE |-> last && !end_marker && block == 5'd0
            && block_count == position)
        else $error("bad error beat");

    // mid-chain beats carry no count, marker or error
    a_mid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> block_count == 6'd0 && !end_marker
            && error == fcw_pkg::ERR_NONE)
        else $error("bad mid-chain beat");

endmodule

bind fat_chain_walker_top fcw_checker u_fcw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .position    (position),
    .block       (block),
    .end_marker  (end_marker),
    .error       (error),
    .block_count (block_count),
    .last        (last)
);
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb - self-checking bench for the file allocation table chain walker
// Loads link tables, walks chains under several table sizes and checks every
// result beat against a chain predictor kept in a small scoreboard class.
// Both handshake sides idle at random, and the output is held off long
// enough for the block to stall its input.
// ============================================================================

typedef struct packed {
    logic [5:0] pos;
    logic [4:0] blk;
    logic       marker;
    logic [1:0] err;
    logic [5:0] count;
    logic       is_last;
} chain_beat_t;

class chain_scoreboard;
    logic [5:0]  links [32];
    bit          written [32];
    logic [5:0]  size_reg;
    chain_beat_t beats [$];
    int          errors;

    function new();
        foreach (written[i])
            written[i] = 1'b0;
        size_reg = 6'd32;
        errors = 0;
    endfunction

    function void set_size(logic [5:0] value);
        size_reg = value;
    endfunction

    // Blocks a walk may visit: the register clamped to the store and block limit.
    function int eff_size();
        int limit;
        limit = (fcw_pkg::TABLE_DEPTH_DEF < fcw_pkg::MAX_BLOCKS) ?
                fcw_pkg::TABLE_DEPTH_DEF : fcw_pkg::MAX_BLOCKS;
        return (int'(size_reg) > limit) ? limit : int'(size_reg);
    endfunction

    function int outstanding();
        return beats.size();
    endfunction

    // First entry a walk from start would read before it is loaded, or -1.
    function int first_unwritten(logic [4:0] start);
        int         sz;
        int         count;
        logic [4:0] cur;
        logic [5:0] nxt;
        sz = eff_size();
        if (start >= sz)
            return -1;
        cur = start;
        count = 1;
        while (1) begin
            if (!written[cur])
                return int'(cur);
            nxt = links[cur];
            if (nxt == fcw_pkg::END_LINK || nxt[5] || nxt >= sz || count >= sz)
                return -1;
            cur = nxt[4:0];
            count++;
        end
    endfunction

    function void queue_beat(int pos, int blk, bit marker, logic [1:0] err,
                             int count, bit is_last);
        chain_beat_t b;
        b.pos     = 6'(pos);
        b.blk     = 5'(blk);
        b.marker  = marker;
        b.err     = err;
        b.count   = 6'(count);
        b.is_last = is_last;
        beats.push_back(b);
    endfunction

    function void predict_walk(logic [4:0] start);
        int         sz;
        int         count;
        logic [4:0] cur;
        logic [5:0] nxt;
        sz = eff_size();
        if (start >= sz) begin
            queue_beat(0, 0, 1'b0, fcw_pkg::ERR_START, 0, 1'b1);
            return;
        end
        cur = start;
        queue_beat(0, int'(cur), 1'b0, fcw_pkg::ERR_NONE, 0, 1'b0);
        count = 1;
        while (1) begin
            nxt = links[cur];
            if (nxt == fcw_pkg::END_LINK) begin
                // the marker counts itself in the block count
                queue_beat(count, 0, 1'b1, fcw_pkg::ERR_NONE, count + 1, 1'b1);
                return;
            end
            if (nxt[5] || nxt >= sz) begin
                queue_beat(count, 0, 1'b0, fcw_pkg::ERR_LINK, count, 1'b1);
                return;
            end
            if (count >= sz) begin
                queue_beat(count, 0, 1'b0, fcw_pkg::ERR_TOO_LONG, count, 1'b1);
                return;
            end
            cur = nxt[4:0];
            queue_beat(count, int'(cur), 1'b0, fcw_pkg::ERR_NONE, 0, 1'b0);
            count++;
        end
    endfunction

    function void note_input(logic m, logic [4:0] idx, logic [5:0] lnk,
                             logic [4:0] start);
        if (m == fcw_pkg::MODE_LOAD) begin
            links[idx] = lnk;
            written[idx] = 1'b1;
        end
        else
            predict_walk(start);
    endfunction

    function void compare(string field, logic [5:0] want_v, logic [5:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, field, want_v, got_v);
            errors++;
        end
    endfunction

    function void check_result(chain_beat_t got);
        chain_beat_t want;
        if (beats.size() == 0) begin
            $display("%0t: unexpected beat: expected none, actual pos %0d blk %0d err %0d",
                     $time, got.pos, got.blk, got.err);
            errors++;
            return;
        end
        want = beats.pop_front();
        compare("position", want.pos, got.pos);
        compare("block", 6'(want.blk), 6'(got.blk));
        compare("end_marker", 6'(want.marker), 6'(got.marker));
        compare("error", 6'(want.err), 6'(got.err));
        compare("block_count", want.count, got.count);
        compare("last", 6'(want.is_last), 6'(got.is_last));
    endfunction
endclass

module tb;

    localparam logic MODE_WALK     = 1'b1;   // the package names only the load mode
    localparam int   SETTLE_CYCLES = 40;     // more than a full walk plus the queue
    localparam int   LONG_HOLD     = 400;
    localparam int   LIMIT         = 1000000;
    localparam int   PHASE_ITEMS   = 33;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [5:0] cfg_wr_data;
    logic       in_valid;
    logic       in_stall;
    logic       mode;
    logic [4:0] entry_index;
    logic [5:0] entry_link;
    logic [4:0] start_block;
    logic       out_valid;
    logic       out_stall;
    logic [5:0] position;
    logic [4:0] block;
    logic       end_marker;
    logic [1:0] error;
    logic [5:0] block_count;
    logic       last;

    chain_scoreboard sb = new();

    bit in_calm;        // sender offers beats back to back
    bit out_calm;       // receiver takes beats back to back
    bit hold_request;   // ask the receiver for one long hold-off
    int items_sent;
    int cycle_count;

    fat_chain_walker_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .entry_index (entry_index),
        .entry_link  (entry_link),
        .start_block (start_block),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position),
        .block       (block),
        .end_marker  (end_marker),
        .error       (error),
        .block_count (block_count),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run as failed if it has not finished by the cycle limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: take result beats, draw a stall after each one, and hold off
    // for a long stretch once when asked. Sample before the edge settles, drive
    // stall with one nonblocking update per edge.
    initial
    begin
        int stall_left;
        int hold_left;
        chain_beat_t got;
        stall_left = 0;
        hold_left = 0;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.pos     = position;
                got.blk     = block;
                got.marker  = end_marker;
                got.err     = error;
                got.count   = block_count;
                got.is_last = last;
                sb.check_result(got);
                stall_left = out_calm ? 0 : $urandom_range(0, 12);
            end
            if (hold_request)
            begin
                hold_left = LONG_HOLD;
                hold_request = 1'b0;
            end
            out_stall <= (stall_left > 0) || (hold_left > 0);
            if (stall_left > 0)
                stall_left--;
            if (hold_left > 0)
                hold_left--;
        end
    end

    // Offer one input beat after a random gap and hold it until accepted.
    // Valid stays high on return, so the next call either replaces the payload
    // at once or drops valid for its gap.
    task automatic send_item(logic m, logic [4:0] idx, logic [5:0] lnk,
                             logic [4:0] st);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        entry_index <= idx;
        entry_link  <= lnk;
        start_block <= st;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(m, idx, lnk, st);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted beat has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // Change the table size only with the block idle: drained, and past any
    // load still working its way through the queue.
    task automatic write_table_size(logic [5:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_size(value);
    endtask

    // Walk from st, first loading any entry the walk would read while still
    // unwritten. Unused fields of the walk beat carry random bits.
    task automatic walk_from(logic [4:0] st);
        int hole;
        hole = sb.first_unwritten(st);
        while (hole >= 0)
        begin
            send_item(fcw_pkg::MODE_LOAD, 5'(hole), 6'($urandom), 5'($urandom));
            hole = sb.first_unwritten(st);
        end
        send_item(MODE_WALK, 5'($urandom), 6'($urandom), st);
    endtask

    // Load a well-formed chain over distinct random blocks, sometimes with a
    // broken tail, then walk it from one of its blocks. Mostly short chains,
    // now and then one as long as the table.
    task automatic send_chain();
        int         sz;
        int         len;
        int         i;
        int         j;
        logic [4:0] order [32];
        logic [4:0] tmp;
        logic [5:0] tail;
        sz = sb.eff_size();
        if (sz == 0)
        begin
            walk_from(5'($urandom));
            return;
        end
        for (i = 0; i < sz; i++)
            order[i] = 5'(i);
        for (i = 0; i < sz - 1; i++)
        begin
            j = $urandom_range(i, sz - 1);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        len = ($urandom_range(0, 9) == 0) ? sz : $urandom_range(1, (sz < 6) ? sz : 6);
        for (i = 0; i < len; i++)
        begin
            if (i == len - 1)
                tail = ($urandom_range(0, 4) == 0) ? 6'($urandom) : fcw_pkg::END_LINK;
            else
                tail = {1'b0, order[i + 1]};
            send_item(fcw_pkg::MODE_LOAD, order[i], tail, 5'($urandom));
        end
        walk_from(order[$urandom_range(0, len - 1)]);
    endtask

    // Mostly chains; the rest is stray loads and walks from anywhere.
    task automatic run_phase(int n_items);
        int stop_at;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 9) < 7)
                send_chain();
            else if ($urandom_range(0, 1) == 0)
                send_item(fcw_pkg::MODE_LOAD, 5'($urandom), 6'($urandom), 5'($urandom));
            else
                walk_from(5'($urandom));
        end
    endtask

    initial
    begin
        logic [5:0] phase_sizes [9];
        int p;
        // Hold every input at a known value and assert reset from time zero.
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 6'd0;
        in_valid    <= 1'b0;
        mode        <= fcw_pkg::MODE_LOAD;
        entry_index <= 5'd0;
        entry_link  <= 6'd0;
        start_block <= 5'd0;
        in_calm      = 1'b0;
        out_calm     = 1'b0;
        hold_request = 1'b0;
        items_sent   = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full table, extreme links and starts, each way a walk ends.
        write_table_size(6'd32);
        send_item(fcw_pkg::MODE_LOAD, 5'd0, fcw_pkg::END_LINK, 5'd0);  // one-block chain
        send_item(fcw_pkg::MODE_LOAD, 5'd31, 6'd5, 5'd31);
        send_item(fcw_pkg::MODE_LOAD, 5'd5, fcw_pkg::END_LINK, 5'd0);
        send_item(fcw_pkg::MODE_LOAD, 5'd7, 6'b100000, 5'd0);     // most negative link
        send_item(fcw_pkg::MODE_LOAD, 5'd3, 6'd31, 5'd0);         // largest link
        send_item(fcw_pkg::MODE_LOAD, 5'd10, 6'd11, 5'd0);        // two-block loop
        send_item(fcw_pkg::MODE_LOAD, 5'd11, 6'd10, 5'd0);
        walk_from(5'd0);
        walk_from(5'd31);
        walk_from(5'd7);
        walk_from(5'd3);
        walk_from(5'd10);                                // loop runs past the table

        // Smallest table: a start in range, a start out of range, then a block linking to itself.
        write_table_size(6'd1);
        walk_from(5'd0);
        walk_from(5'd31);
        send_item(fcw_pkg::MODE_LOAD, 5'd0, 6'd0, 5'd0);
        walk_from(5'd0);

        // Empty table: every walk is a start error.
        write_table_size(6'd0);
        walk_from(5'd0);

        // Oversized register clamps to the full table.
        write_table_size(6'd63);
        walk_from(5'd10);
        walk_from(5'd3);

        // Random phases over a spread of table sizes.
        phase_sizes = '{6'd32, 6'($urandom_range(3, 31)), 6'd2, 6'd63,
                        6'($urandom_range(33, 62)), 6'd1, 6'd0,
                        6'($urandom_range(3, 32)), 6'd32};
        for (p = 0; p < 9; p++)
        begin
            write_table_size(phase_sizes[p]);
            in_calm  = (p == 3) || ($urandom_range(0, 2) == 0);
            out_calm = (p == 3) || ($urandom_range(0, 2) == 0);
            if (p == 0)
            begin
                // hold the output off while the sender keeps offering walks
                in_calm = 1'b1;
                hold_request = 1'b1;
            end
            if (p == 2)
            begin
                run_phase(15);
                drain_results();     // pause the sender until all beats are in
                run_phase(PHASE_ITEMS - 15);
            end
            else
                run_phase(PHASE_ITEMS);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
